// ===== rtl/core/bbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bbpe_pkg
// shared types, widths and arithmetic helpers of the bezier patch evaluator
// ----------------------------------------------------------------------------
package bbpe_pkg;

    localparam int COORD_BITS  = 16;
    localparam int GRID_BITS   = 10;
    localparam int NUM_BITS    = GRID_BITS + 16;
    localparam int CNT_BITS    = 5;
    localparam int W_BITS      = 17;
    localparam int WP_BITS     = 2 * W_BITS;
    localparam int PROD_BITS   = WP_BITS + COORD_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int OUT_BITS    = 24;
    localparam int MEM_DEPTH   = 16;
    localparam int MEM_AW      = 4;
    localparam int MEM_W       = 2 * COORD_BITS;

    localparam logic [W_BITS-1:0]    ONE_Q16      = W_BITS'(65536);
    localparam logic [GRID_BITS-1:0] STEPS_RESET  = GRID_BITS'(100);
    localparam logic [CNT_BITS-1:0]  DIV_LAST     = CNT_BITS'(NUM_BITS - 1);
    localparam logic [CNT_BITS-1:0]  ACC_ISSUE    = CNT_BITS'(MEM_DEPTH);
    localparam logic [CNT_BITS-1:0]  ACC_LAST     = CNT_BITS'(MEM_DEPTH + 2);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WSQ,
        ST_WGT,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef logic [W_BITS-1:0] t_weights [4];

    // round a Q.48 product to Q1.16, halves up
    function automatic logic [W_BITS-1:0] f_rnd32(input logic [51:0] p);
        logic [52:0] r;
        r = {1'b0, p} + 53'(64'h8000_0000);
        return r[32 +: W_BITS];
    endfunction

    // cubic bernstein weights from t, s and their squares
    function automatic t_weights f_bern(input logic [W_BITS-1:0] t,
                                        input logic [W_BITS-1:0] s,
                                        input logic [WP_BITS-1:0] t2,
                                        input logic [WP_BITS-1:0] s2);
        t_weights   w;
        logic [50:0] p0, p1, p2, p3;
        p0 = 51'(s2) * 51'(s);
        p1 = 51'(s2) * 51'(t);
        p2 = 51'(t2) * 51'(s);
        p3 = 51'(t2) * 51'(t);
        w[0] = f_rnd32({1'b0, p0});
        w[1] = f_rnd32({1'b0, p1} + {p1, 1'b0});
        w[2] = f_rnd32({1'b0, p2} + {p2, 1'b0});
        w[3] = f_rnd32({1'b0, p3});
        return w;
    endfunction

endpackage

// ===== rtl/core/bbpe_ram.sv =====
// ----------------------------------------------------------------------------
// bbpe_ram
// single port synchronous ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module bbpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bicubic_bezier_patch_eval.sv =====
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval
// evaluates one bicubic bezier patch held in a 16 entry control point ram
// ----------------------------------------------------------------------------
// a load request is taken while idle, one per cycle, and returns nothing
// an evaluate request runs bit serial parameter division, the weights, 16 ram
// reads (one ram port, one control point a cycle) through the read + weight
// product, coordinate product and sum stages, and a round into the output
// register; no new request is taken until the result is loaded there
// reset (i_rst_n low, synchronous): grid_steps back to 100, all slots read 0
module bicubic_bezier_patch_eval
    import bbpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration: grid_steps
    input  logic                  i_cfg_wr_en,
    input  logic [GRID_BITS-1:0]  i_cfg_wr_data,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // point_index[3:0], ctrl_x[19:4], ctrl_y[35:20], grid_u[45:36], grid_v[55:46]
    input  logic [55:0]           s_axis_tdata,
    // req_type[0]
    input  logic [0:0]            s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // surf_x[23:0], surf_y[47:24]
    output logic [47:0]           m_axis_tdata
);

    // request fields
    logic [3:0]            w_pidx;
    logic [COORD_BITS-1:0] w_cx, w_cy;
    logic [GRID_BITS-1:0]  w_gu, w_gv, w_n;
    assign w_pidx = s_axis_tdata[3:0];
    assign w_cx   = s_axis_tdata[19:4];
    assign w_cy   = s_axis_tdata[35:20];
    assign w_gu   = s_axis_tdata[45:36];
    assign w_gv   = s_axis_tdata[55:46];

    logic [GRID_BITS-1:0] r_steps;
    t_state r_state, n_state;

    logic w_acc_req, w_load, w_eval;
    assign w_acc_req = s_axis_tvalid && s_axis_tready;
    assign w_load    = w_acc_req && (s_axis_tuser[0] == REQ_LOAD);
    assign w_eval    = w_acc_req && (s_axis_tuser[0] == REQ_EVAL);

    // a zero step count behaves as one
    assign w_n = (r_steps == '0) ? GRID_BITS'(1) : r_steps;

    logic [CNT_BITS-1:0]  r_cnt;
    logic                 w_out_free;
    assign w_out_free = !m_axis_tvalid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_eval) n_state = ST_DIV;
            ST_DIV:  if (r_cnt == DIV_LAST) n_state = ST_WSQ;
            ST_WSQ:  n_state = ST_WGT;
            ST_WGT:  n_state = ST_ACC;
            ST_ACC:  if (r_cnt == ACC_LAST) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    logic w_div_step, w_issue, w_out_load;
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_step    = 1'b0;
        w_issue       = 1'b0;
        w_out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_DIV:  w_div_step    = 1'b1;
            ST_ACC:  w_issue       = (r_cnt < ACC_ISSUE);
            ST_DONE: w_out_load    = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_steps <= STEPS_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_steps <= i_cfg_wr_data;
            end
        end
    end

    // step counter, shared by the divider and the read sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state != n_state) begin
            r_cnt <= '0;
        end else if (r_state == ST_DIV || r_state == ST_ACC) begin
            r_cnt <= r_cnt + CNT_BITS'(1);
        end
    end

    // bit serial restoring division, u and v side by side
    // numerator shifts out msb first, quotient bits shift in at the bottom
    logic [NUM_BITS-1:0]  r_nu, r_nv;
    logic [GRID_BITS:0]   r_ru, r_rv;
    logic [GRID_BITS-1:0] r_dn;
    logic                 r_sat_u, r_sat_v;
    logic [GRID_BITS:0]   w_tu_rem, w_tv_rem;
    logic                 w_qu, w_qv;

    assign w_tu_rem = {r_ru[GRID_BITS-1:0], r_nu[NUM_BITS-1]};
    assign w_tv_rem = {r_rv[GRID_BITS-1:0], r_nv[NUM_BITS-1]};
    assign w_qu     = (w_tu_rem >= {1'b0, r_dn});
    assign w_qv     = (w_tv_rem >= {1'b0, r_dn});

    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_nu    <= {w_gu, 16'b0} + NUM_BITS'(w_n >> 1);
            r_nv    <= {w_gv, 16'b0} + NUM_BITS'(w_n >> 1);
            r_ru    <= '0;
            r_rv    <= '0;
            r_dn    <= w_n;
            r_sat_u <= (w_gu >= w_n);
            r_sat_v <= (w_gv >= w_n);
        end else if (w_div_step) begin
            r_nu <= {r_nu[NUM_BITS-2:0], w_qu};
            r_nv <= {r_nv[NUM_BITS-2:0], w_qv};
            r_ru <= w_qu ? (w_tu_rem - {1'b0, r_dn}) : w_tu_rem;
            r_rv <= w_qv ? (w_tv_rem - {1'b0, r_dn}) : w_tv_rem;
        end
    end

    // parameters, their complements and the squares of both
    logic [W_BITS-1:0]  w_tu, w_tv;
    logic [W_BITS-1:0]  r_tu, r_su, r_tv, r_sv;
    logic [WP_BITS-1:0] r_tu2, r_su2, r_tv2, r_sv2;

    assign w_tu = r_sat_u ? ONE_Q16 : {1'b0, r_nu[15:0]};
    assign w_tv = r_sat_v ? ONE_Q16 : {1'b0, r_nv[15:0]};

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WSQ) begin
            r_tu  <= w_tu;
            r_su  <= ONE_Q16 - w_tu;
            r_tv  <= w_tv;
            r_sv  <= ONE_Q16 - w_tv;
            r_tu2 <= WP_BITS'(w_tu) * WP_BITS'(w_tu);
            r_su2 <= WP_BITS'(ONE_Q16 - w_tu) * WP_BITS'(ONE_Q16 - w_tu);
            r_tv2 <= WP_BITS'(w_tv) * WP_BITS'(w_tv);
            r_sv2 <= WP_BITS'(ONE_Q16 - w_tv) * WP_BITS'(ONE_Q16 - w_tv);
        end
    end

    // bernstein weights
    t_weights r_wu, r_wv;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WGT) begin
            r_wu <= f_bern(r_tu, r_su, r_tu2, r_su2);
            r_wv <= f_bern(r_tv, r_sv, r_tv2, r_sv2);
        end
    end

    // control point ram, valid bits stand in for the reset clear
    logic [MEM_DEPTH-1:0] r_valid;
    logic [MEM_AW-1:0]    w_addr;
    logic [MEM_W-1:0]     w_rdata;

    assign w_addr = w_load ? w_pidx : r_cnt[MEM_AW-1:0];

    bbpe_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_addr  (w_addr),
        .i_wdata ({w_cx, w_cy}),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_load) begin
            r_valid[w_pidx] <= 1'b1;
        end
    end

    // accumulate pipeline: read + weight product, coordinate product, sum
    // slot k of group g is weighted by wu[k] * wv[g]
    logic                 r_s1, r_s2, r_ok;
    logic [WP_BITS-1:0]   r_wp;
    logic signed [PROD_BITS-1:0] r_px, r_py;
    logic signed [ACC_BITS-1:0]  r_ax, r_ay;
    logic signed [COORD_BITS-1:0] w_px, w_py;

    assign w_px = r_ok ? w_rdata[MEM_W-1:COORD_BITS]  : '0;
    assign w_py = r_ok ? w_rdata[COORD_BITS-1:0]      : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= 1'b0;
            r_s2 <= 1'b0;
        end else begin
            r_s1 <= w_issue;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_ok <= r_valid[r_cnt[MEM_AW-1:0]];
            r_wp <= WP_BITS'(r_wu[r_cnt[1:0]]) * WP_BITS'(r_wv[r_cnt[3:2]]);
        end
        if (r_s1) begin
            r_px <= $signed({1'b0, r_wp[WP_BITS-2:0]}) * PROD_BITS'(w_px);
            r_py <= $signed({1'b0, r_wp[WP_BITS-2:0]}) * PROD_BITS'(w_py);
        end
        if (w_eval) begin
            r_ax <= '0;
            r_ay <= '0;
        end else if (r_s2) begin
            r_ax <= r_ax + ACC_BITS'(r_px);
            r_ay <= r_ay + ACC_BITS'(r_py);
        end
    end

    // round Q.32 to Q.8 (halves up) and saturate to 24 bits
    function automatic logic [OUT_BITS-1:0] f_q8(input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] y;
        logic signed [ACC_BITS-25:0] r;
        y = v + ACC_BITS'(24'h80_0000);
        r = y[ACC_BITS-1:24];
        if (r > $signed((ACC_BITS-24)'(24'h7F_FFFF))) begin
            return 24'h7F_FFFF;
        end else if (r < -$signed((ACC_BITS-24)'(24'h80_0000))) begin
            return 24'h80_0000;
        end
        return r[OUT_BITS-1:0];
    endfunction

    // output register, holds the result until taken
    logic r_ovld;
    logic [47:0] r_odata;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_load) begin
            r_ovld <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
        if (w_out_load) begin
            r_odata <= {f_q8(r_ay), f_q8(r_ax)};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

endmodule

// ===== test/bicubic_bezier_patch_eval_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval_chk
// watches the request and result streams, predicts each surface point and
// compares it with what the block returns, reporting x and y apart
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval_chk
    import bbpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [GRID_BITS-1:0] i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,
    input  logic [0:0]           s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [47:0]          m_axis_tdata,
    output int                   o_errors,
    output int                   o_pending
);

    logic signed [15:0]   pts_x [16];
    logic signed [15:0]   pts_y [16];
    logic [GRID_BITS-1:0] steps;
    logic [47:0]          surf_q [$];

    function automatic longint param_of(input longint idx, input longint n);
        if (n == 0) n = 1;
        if (idx >= n) return 65536;
        return ((idx << 16) + n / 2) / n;
    endfunction

    function automatic void weights_of(input longint t, output longint w [4]);
        longint s;
        longint half;
        s = 65536 - t;
        half = 64'h8000_0000;
        w[0] = (s * s * s + half) >>> 32;
        w[1] = (3 * t * s * s + half) >>> 32;
        w[2] = (3 * t * t * s + half) >>> 32;
        w[3] = (t * t * t + half) >>> 32;
    endfunction

    function automatic logic [23:0] round_q8(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 23)) >>> 24;
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    function automatic logic [47:0] surface_point(input longint gu, input longint gv);
        longint wu [4];
        longint wv [4];
        longint ax, ay, gx, gy;
        weights_of(param_of(gu, steps), wu);
        weights_of(param_of(gv, steps), wv);
        ax = 0;
        ay = 0;
        for (int g = 0; g < 4; g++) begin
            gx = 0;
            gy = 0;
            for (int k = 0; k < 4; k++) begin
                gx += wu[k] * longint'(pts_x[g*4+k]);
                gy += wu[k] * longint'(pts_y[g*4+k]);
            end
            ax += wv[g] * gx;
            ay += wv[g] * gy;
        end
        return {round_q8(ay), round_q8(ax)};
    endfunction

    assign o_pending = surf_q.size();

    always @(posedge i_clk) begin
        logic [47:0] want;
        if (!i_rst_n) begin
            steps    <= STEPS_RESET;
            o_errors <= 0;
            for (int i = 0; i < 16; i++) begin
                pts_x[i] = '0;
                pts_y[i] = '0;
            end
            surf_q.delete();
        end else begin
            if (i_cfg_wr_en) steps <= i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == REQ_LOAD) begin
                    pts_x[s_axis_tdata[3:0]] = s_axis_tdata[19:4];
                    pts_y[s_axis_tdata[3:0]] = s_axis_tdata[35:20];
                end else begin
                    surf_q.push_back(surface_point(s_axis_tdata[45:36],
                                                   s_axis_tdata[55:46]));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (surf_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result %h", m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    want = surf_q.pop_front();
                    if (want != m_axis_tdata) begin
                        if (o_errors < 10)
                            $display("surface mismatch: x exp %h got %h, y exp %h got %h",
                                     want[23:0], m_axis_tdata[23:0],
                                     want[47:24], m_axis_tdata[47:24]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== test/bicubic_bezier_patch_eval_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval_tb
// drives load and evaluate requests under random gaps and back pressure,
// walks grid_steps through several settings, and reports the verdict
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval_tb;
    import bbpe_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [GRID_BITS-1:0] i_cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [55:0]          s_axis_tdata;   // point_index, ctrl_x, ctrl_y, grid_u, grid_v
    logic [0:0]           s_axis_tuser;   // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [47:0]          m_axis_tdata;   // surf_x, surf_y
    int                   errors;
    int                   pending;
    bit                   long_hold;      // set by stimulus to ask for a long receiver stall

    bicubic_bezier_patch_eval dut (.*);

    bicubic_bezier_patch_eval_chk u_chk (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_wr_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // send one request, with a random gap before it
    // tvalid stays up after acceptance until the next request or a drain
    task automatic send_request(input logic kind, input logic [3:0] slot,
                                input logic [15:0] cx, input logic [15:0] cy,
                                input logic [9:0] gu, input logic [9:0] gv,
                                input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {gv, gu, cy, cx, slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_point(input logic [3:0] slot, input logic [15:0] cx,
                              input logic [15:0] cy);
        send_request(REQ_LOAD, slot, cx, cy, 10'($urandom), 10'($urandom));
    endtask

    task automatic eval_at(input logic [9:0] gu, input logic [9:0] gv);
        send_request(REQ_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), gu, gv);
    endtask

    // stop offering, wait until every surface point is back, then let the block settle
    task automatic drain;
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (60) @(negedge i_clk);
    endtask

    task automatic set_steps(input logic [9:0] n);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= n;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [9:0] grid_index(input logic [9:0] n);
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return n;
            2: return 10'($urandom);
            3: return 10'd1023;
            default: return 10'($urandom_range(0, n));
        endcase
    endfunction

    // receiver: random stall per result, one long hold when asked
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // stimulus
    initial begin
        logic [9:0] steps_now;
        logic [9:0] steps_set [6];
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_LOAD;
        long_hold     = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // evaluate before any load: all slots read zero
        eval_at(10'd50, 10'd50);
        // extremes of coordinates in every slot
        for (int i = 0; i < 16; i++)
            load_point(4'(i), (i % 2) ? 16'h7fff : 16'h8000,
                       (i % 3) ? 16'h8000 : 16'h7fff);
        eval_at(10'd0, 10'd0);
        eval_at(10'd100, 10'd100);
        eval_at(10'd1023, 10'd0);
        eval_at(10'd33, 10'd67);
        eval_at(10'd0, 10'd1023);
        steps_now = 10'd100;

        // zero step count acts as one, then the smallest and largest counts, then 3, 100 and 517
        steps_set = '{10'd0, 10'd1, 10'd1023, 10'd3, 10'd100, 10'd517};
        for (int p = 0; p < 6; p++) begin
            set_steps(steps_set[p]);
            steps_now = steps_set[p];
            for (int j = 0; j < 100; j++) begin
                if ($urandom_range(0, 2) == 0)
                    load_point(4'($urandom), 16'($urandom), 16'($urandom));
                else
                    eval_at(grid_index(steps_now), grid_index(steps_now));
                // mid phase: stall the receiver and keep offering requests
                if (p == 2 && j == 20) begin
                    long_hold = 1;
                    for (int b = 0; b < 12; b++)
                        send_request(REQ_EVAL, 4'($urandom), 16'($urandom),
                                     16'($urandom), grid_index(steps_now),
                                     grid_index(steps_now), 1);
                end
            end
        end
        drain();

        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
